// ===== sv/aaid_pkg.sv =====
package aaid_pkg;

  localparam int MAX_SIDE_DEF = 2048;
  localparam int CH_N         = 4;
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUO_W        = PIX_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 3'd3;

  // width of one packed command word between front and back
  function automatic int cmd_width(int max_side);
    int side_w;
    int idx_w;
    side_w = $clog2(max_side + 1);
    idx_w  = $clog2(max_side);
    return CH_N * PIX_W + 6 * side_w + 2 * idx_w + 3;
  endfunction

endpackage

// ===== sv/aaid_ram.sv =====
module aaid_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/aaid_queue.sv =====
module aaid_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = cnt_r != CNT_W'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/aaid_front.sv =====
module aaid_front import aaid_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PIX_W-1:0]                in_red,
  input  logic [PIX_W-1:0]                in_green,
  input  logic [PIX_W-1:0]                in_blue,
  input  logic [PIX_W-1:0]                in_alpha,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output logic [cmd_width(MAX_SIDE)-1:0]  cmd_data,
  input  logic                            clearing,
  output logic                            clear_req
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int AREA_W = 2 * SIDE_W;

  typedef struct packed {
    logic [CH_N-1:0][PIX_W-1:0] pix;
    logic [SIDE_W-1:0]          w0;
    logic [SIDE_W-1:0]          w1;
    logic [SIDE_W-1:0]          h0;
    logic [SIDE_W-1:0]          h1;
    logic [IDX_W-1:0]           a0;
    logic [IDX_W-1:0]           a1;
    logic [AREA_W-1:0]          t;
    logic                       emit;
    logic                       fdone;
    logic                       swap;
  } cmd_t;

  function automatic logic [SIDE_W-1:0] clamp_side(logic [CFG_W-1:0] v,
                                                   logic [SIDE_W-1:0] hi);
    if (v == '0) return SIDE_W'(1);
    if (32'(v) > 32'(hi)) return hi;
    return SIDE_W'(v);
  endfunction

  logic [CFG_W-1:0]  src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [SIDE_W-1:0] sw, sh, tw, th;
  logic [AREA_W-1:0] t_r;
  logic [SIDE_W-1:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic [AREA_W-1:0] xs_r, bxb_r, ys_r, byb_r;
  logic [AREA_W-1:0] xe, bx, ye, by;
  logic              col_done, row_done, row_end, frame_end, acc;
  cmd_t              cmd;

  assign clear_req = cfg_we && (cfg_index == REG_SRC_W || cfg_index == REG_SRC_H ||
                                cfg_index == REG_TGT_W || cfg_index == REG_TGT_H);

  assign sw = clamp_side(src_w_r, SIDE_W'(MAX_SIDE));
  assign sh = clamp_side(src_h_r, SIDE_W'(MAX_SIDE));
  assign tw = clamp_side(tgt_w_r, sw);
  assign th = clamp_side(tgt_h_r, sh);

  assign xe       = xs_r + AREA_W'(tw);
  assign bx       = bxb_r + AREA_W'(sw);
  assign col_done = xe >= bx;
  assign ye       = ys_r + AREA_W'(th);
  assign by       = byb_r + AREA_W'(sh);
  assign row_done = ye >= by;

  assign row_end   = ({1'b0, in_col_r} + 1'b1) >= {1'b0, sw};
  assign frame_end = row_end && (({1'b0, in_row_r} + 1'b1) >= {1'b0, sh});

  assign in_ready  = cmd_ready && !clearing && !cfg_we;
  assign cmd_valid = in_valid && !clearing && !cfg_we;
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd.pix   = {in_alpha, in_blue, in_green, in_red};
    cmd.w0    = col_done ? SIDE_W'(bx - xs_r) : tw;
    cmd.w1    = col_done ? SIDE_W'(xe - bx) : '0;
    cmd.h0    = row_done ? SIDE_W'(by - ys_r) : th;
    cmd.h1    = row_done ? SIDE_W'(ye - by) : '0;
    cmd.a0    = out_col_r[IDX_W-1:0];
    cmd.a1    = IDX_W'(out_col_r + 1'b1);
    cmd.t     = t_r;
    cmd.emit  = col_done && row_done;
    cmd.fdone = (({1'b0, out_row_r} + 1'b1) == {1'b0, th}) &&
                (({1'b0, out_col_r} + 1'b1) == {1'b0, tw});
    cmd.swap  = row_end && row_done;
  end

  assign cmd_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= CFG_W'(1);
      src_h_r <= CFG_W'(1);
      tgt_w_r <= CFG_W'(1);
      tgt_h_r <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W: src_w_r <= cfg_data;
        REG_SRC_H: src_h_r <= cfg_data;
        REG_TGT_W: tgt_w_r <= cfg_data;
        REG_TGT_H: tgt_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t_r <= AREA_W'(sw) * AREA_W'(sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_req || (acc && frame_end)) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      xs_r      <= '0;
      bxb_r     <= '0;
      ys_r      <= '0;
      byb_r     <= '0;
    end else if (acc) begin
      if (row_end) begin
        in_col_r  <= '0;
        out_col_r <= '0;
        xs_r      <= '0;
        bxb_r     <= '0;
        in_row_r  <= in_row_r + 1'b1;
        ys_r      <= ye;
        if (row_done) begin
          out_row_r <= out_row_r + 1'b1;
          byb_r     <= by;
        end
      end else begin
        in_col_r <= in_col_r + 1'b1;
        xs_r     <= xe;
        if (col_done) begin
          out_col_r <= out_col_r + 1'b1;
          bxb_r     <= bx;
        end
      end
    end
  end

endmodule

// ===== sv/aaid_back.sv =====
module aaid_back import aaid_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             clear_req,
  output logic                                             clearing,
  input  logic                                             cmd_valid,
  output logic                                             cmd_ready,
  input  logic [cmd_width(MAX_SIDE)-1:0]                   cmd_data,
  output logic                                             div_valid,
  input  logic                                             div_ready,
  output logic [CH_N-1:0][PIX_W+2*$clog2(MAX_SIDE)-1:0]    div_sums,
  output logic [2*$clog2(MAX_SIDE+1)-1:0]                  div_t,
  output logic                                             div_fdone
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int AREA_W = 2 * SIDE_W;
  localparam int SUM_W  = PIX_W + 2 * IDX_W;
  localparam int ROW_W  = CH_N * SUM_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  typedef struct packed {
    logic [CH_N-1:0][PIX_W-1:0] pix;
    logic [SIDE_W-1:0]          w0;
    logic [SIDE_W-1:0]          w1;
    logic [SIDE_W-1:0]          h0;
    logic [SIDE_W-1:0]          h1;
    logic [IDX_W-1:0]           a0;
    logic [IDX_W-1:0]           a1;
    logic [AREA_W-1:0]          t;
    logic                       emit;
    logic                       fdone;
    logic                       swap;
  } cmd_t;

  logic [2:0]                  state_r;
  logic [1:0]                  q_r;
  logic                        sel_r;
  logic [IDX_W-1:0]            clr_cnt_r;
  cmd_t                        cmd_r;
  logic [AREA_W-1:0]           area_r;
  logic [CH_N-1:0][SUM_W-1:0]  prod_r;

  logic                        bank;
  logic [IDX_W-1:0]            addr;
  logic [ROW_W-1:0]            rdata0, rdata1, rdata, wdata;
  logic [CH_N-1:0][SUM_W-1:0]  sum;
  logic                        emit_here, wr_go, re0, re1, we0, we1, last;
  logic [1:0]                  nq;

  assign clearing  = state_r == ST_CLR;
  assign cmd_ready = state_r == ST_IDLE;

  assign bank  = q_r[1] ? ~sel_r : sel_r;
  assign addr  = clearing ? clr_cnt_r : (q_r[0] ? cmd_r.a1 : cmd_r.a0);
  assign rdata = bank ? rdata1 : rdata0;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      sum[c] = rdata[c*SUM_W +: SUM_W] + prod_r[c];
    end
  end

  assign emit_here = (q_r == 2'd0) && cmd_r.emit;
  assign div_valid = (state_r == ST_WR) && emit_here;
  assign div_sums  = sum;
  assign div_t     = cmd_r.t;
  assign div_fdone = cmd_r.fdone;
  assign wr_go     = (state_r == ST_WR) && (!emit_here || div_ready);
  assign wdata     = (clearing || emit_here) ? '0 : sum;

  assign re0 = (state_r == ST_RD) && !bank;
  assign re1 = (state_r == ST_RD) && bank;
  assign we0 = clearing || (wr_go && !bank);
  assign we1 = clearing || (wr_go && bank);

  // walk the quadrants that carry weight: this/next row, first/second column
  always_comb begin
    last = 1'b1;
    nq   = 2'd0;
    case (q_r)
      2'd0: begin
        if (cmd_r.w1 != '0) begin
          last = 1'b0;
          nq   = 2'd1;
        end else if (cmd_r.h1 != '0) begin
          last = 1'b0;
          nq   = 2'd2;
        end
      end
      2'd1: begin
        if (cmd_r.h1 != '0) begin
          last = 1'b0;
          nq   = 2'd2;
        end
      end
      2'd2: begin
        if (cmd_r.w1 != '0) begin
          last = 1'b0;
          nq   = 2'd3;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_req) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
      sel_r     <= 1'b0;
      q_r       <= 2'd0;
    end else begin
      case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IDX_W'(MAX_SIDE - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            q_r     <= 2'd0;
            state_r <= ST_RD;
          end
        end
        ST_RD:  state_r <= ST_MUL;
        ST_MUL: state_r <= ST_WR;
        ST_WR: begin
          if (wr_go) begin
            if (last) begin
              state_r <= ST_IDLE;
              if (cmd_r.swap) begin
                sel_r <= ~sel_r;
              end
            end else begin
              q_r     <= nq;
              state_r <= ST_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid) begin
      cmd_r <= cmd_t'(cmd_data);
    end
    if (state_r == ST_RD) begin
      area_r <= AREA_W'(q_r[0] ? cmd_r.w1 : cmd_r.w0) *
                AREA_W'(q_r[1] ? cmd_r.h1 : cmd_r.h0);
    end
    if (state_r == ST_MUL) begin
      for (int c = 0; c < CH_N; c++) begin
        prod_r[c] <= SUM_W'(cmd_r.pix[c]) * SUM_W'(area_r);
      end
    end
  end

  aaid_ram #(.W(ROW_W), .DEPTH(MAX_SIDE)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (addr),
    .wdata (wdata),
    .re    (re0),
    .raddr (addr),
    .rdata (rdata0)
  );

  aaid_ram #(.W(ROW_W), .DEPTH(MAX_SIDE)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (addr),
    .wdata (wdata),
    .re    (re1),
    .raddr (addr),
    .rdata (rdata1)
  );

endmodule

// ===== sv/aaid_div.sv =====
module aaid_div import aaid_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [CH_N-1:0][PIX_W+2*$clog2(MAX_SIDE)-1:0]  in_sums,
  input  logic [2*$clog2(MAX_SIDE+1)-1:0]                in_t,
  input  logic                                           in_fdone,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [CH_N-1:0][PIX_W-1:0]                     out_pix,
  output logic                                           out_fdone
);

  localparam int SUM_W = PIX_W + 2 * $clog2(MAX_SIDE);
  localparam int DW    = SUM_W + 2;
  localparam int CNT_W = $clog2(QUO_W);

  logic                        busy_r;
  logic                        out_valid_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [DW-1:0]               dsh_r;
  logic [CH_N-1:0][DW-1:0]     rem_r;
  logic [CH_N-1:0][QUO_W-1:0]  quo_r;
  logic                        fdone_r;

  assign in_ready  = !busy_r && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_fdone = fdone_r;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      out_pix[c] = quo_r[c][QUO_W-1] ? '1 : quo_r[c][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // restoring division of 2*sum+T by 2*T, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dsh_r   <= DW'(in_t) << QUO_W;
      fdone_r <= in_fdone;
      for (int c = 0; c < CH_N; c++) begin
        rem_r[c] <= (DW'(in_sums[c]) << 1) + DW'(in_t);
        quo_r[c] <= '0;
      end
    end else if (busy_r) begin
      dsh_r <= dsh_r >> 1;
      for (int c = 0; c < CH_N; c++) begin
        if (rem_r[c] >= dsh_r) begin
          rem_r[c] <= rem_r[c] - dsh_r;
          quo_r[c] <= {quo_r[c][QUO_W-2:0], 1'b1};
        end else begin
          quo_r[c] <= {quo_r[c][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ===== sv/area_average_image_downscale.sv =====
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    in_red, in_green, in_blue, in_alpha
// out_     output     out_valid / out_ready  out_red .. out_alpha, out_frame_done
// cfg_     input      cfg_we                 cfg_index, cfg_data
//
// The back picks up one source pixel at a time and makes a read-multiply-write pass
// over the column sum banks for each destination quadrant it touches, one to four;
// it takes no new pixel until the last pass is written.
// Each output word is then divided in the divider, overlapped with later pixels.
// After reset and after every register write the sum banks are swept clear,
// address by address, with in_ready low; register writes are still taken.
// A stalled output holds the divider; the command queue lets the front keep
// taking pixels while the back waits.
module area_average_image_downscale import aaid_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_blue,
  input  logic [PIX_W-1:0]     in_alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_red,
  output logic [PIX_W-1:0]     out_green,
  output logic [PIX_W-1:0]     out_blue,
  output logic [PIX_W-1:0]     out_alpha,
  output logic                 out_frame_done
);

  localparam int CMD_W  = cmd_width(MAX_SIDE);
  localparam int SUM_W  = PIX_W + 2 * $clog2(MAX_SIDE);
  localparam int AREA_W = 2 * $clog2(MAX_SIDE + 1);

  logic                       clear_req, clearing;
  logic                       f_valid, f_ready;
  logic [CMD_W-1:0]           f_data;
  logic                       b_valid, b_ready;
  logic [CMD_W-1:0]           b_data;
  logic                       div_valid, div_ready, div_fdone;
  logic [CH_N-1:0][SUM_W-1:0] div_sums;
  logic [AREA_W-1:0]          div_t;
  logic [CH_N-1:0][PIX_W-1:0] out_pix;

  // front: hold registers, track source and destination positions, form weights
  aaid_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data),
    .clearing  (clearing),
    .clear_req (clear_req)
  );

  aaid_queue #(.W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n && !clear_req),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  // back: accumulate weighted pixels into the two ping-pong row banks
  aaid_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_req (clear_req),
    .clearing  (clearing),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .div_valid (div_valid),
    .div_ready (div_ready),
    .div_sums  (div_sums),
    .div_t     (div_t),
    .div_fdone (div_fdone)
  );

  // divide finished sums by total weight, round half up, hold the output word
  aaid_div #(.MAX_SIDE(MAX_SIDE)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_sums   (div_sums),
    .in_t      (div_t),
    .in_fdone  (div_fdone),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (out_pix),
    .out_fdone (out_frame_done)
  );

  assign out_red   = out_pix[0];
  assign out_green = out_pix[1];
  assign out_blue  = out_pix[2];
  assign out_alpha = out_pix[3];

endmodule
